FILE: rtl/core/sepg_pkg.sv
// Shared constants and codes for the scroll easing position generator.
// Fixed-point widths, register indexes, direction, alignment and curve codes.
// No dependencies.
package sepg_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int CENTER_OFFSET = 20;

  // Width of a fraction in [0, ONE].
  localparam int FW = FRACTION_BITS + 1;
  // Width of a frame count.
  localparam int DW = 17;
  // Width of the position arithmetic, one bit above the port width.
  localparam int PW = 19;
  // Width of one operand of the shared multiplier.
  localparam int MW = (FW > DW) ? FW : DW;
  // Width of the cubic blend sum before clamping.
  localparam int VW = FW + 4;

  localparam logic [FW-1:0] FX_ONE  = FW'(1) << FRACTION_BITS;
  localparam logic [FW-1:0] FX_HALF = FW'(1) << (FRACTION_BITS - 1);

  localparam logic [2:0] REG_DIRECTION      = 3'd0;
  localparam logic [2:0] REG_ALIGNMENT      = 3'd1;
  localparam logic [2:0] REG_EASE_KIND      = 3'd2;
  localparam logic [2:0] REG_WINDOW_WIDTH   = 3'd3;
  localparam logic [2:0] REG_WINDOW_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_CONTENT_WIDTH  = 3'd5;
  localparam logic [2:0] REG_CONTENT_HEIGHT = 3'd6;
  localparam logic [2:0] REG_PASS_COUNT     = 3'd7;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [1:0] ALIGN_NEAR   = 2'd0;
  localparam logic [1:0] ALIGN_FAR    = 2'd1;
  localparam logic [1:0] ALIGN_CENTER = 2'd2;

  localparam logic [2:0] EASE_LINEAR = 3'd0;
  localparam logic [2:0] EASE_IN     = 3'd1;
  localparam logic [2:0] EASE_OUT    = 3'd2;
  localparam logic [2:0] EASE_IN_OUT = 3'd3;
  localparam logic [2:0] EASE_OUT_IN = 3'd4;

endpackage

FILE: rtl/core/scroll_easing_position_generator.sv
// Top level of the scroll easing position generator.
// Holds the configuration registers, run state, sequencer and shared multiplier.
// Depends on sepg_pkg and sepg_div.
// Each input word is one display frame tick; in_restart set reloads the pass
// count and starts again at frame zero. Each input word yields exactly one
// output word with the x and y offsets of the content, a pass end flag and a
// done flag (positions are zero once no passes remain).
// Configuration is written through the cfg channel, which is always ready;
// the user must write it only while no frame is in flight, which the block itself does not enforce.
// A frame passes from acceptance through the divider, which produces one
// progress bit per cycle, then through the ease state and the multiplier, used
// up to three times in sequence; a linear frame uses the multiplier only once.
// A zero frame count skips the divider, and a frame that finds the block done
// goes straight to the output state. One frame is worked on at a time; in_stall
// is high from acceptance until the result is loaded. A stalled output word
// holds while the next frame is accepted and computed; the sequencer waits only
// if that result is ready first.
// Reset clears the configuration, run state and output valid flag, so the
// block starts idle and done.
module scroll_easing_position_generator
  import sepg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_x_position,
  output logic signed [17:0] out_y_position,
  output logic               out_pass_end,
  output logic               out_done_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_EASE = 8'b0000_0100,
    S_MUL1 = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_FIN  = 8'b0010_0000,
    S_MUL3 = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic [1:0]  dir_r;
  logic [1:0]  align_r;
  logic [2:0]  kind_r;
  logic [13:0] ww_r;
  logic [13:0] wh_r;
  logic [15:0] cw_r;
  logic [13:0] ch_r;
  logic [7:0]  pcnt_r;

  logic [17:0] frame_r;
  logic [7:0]  passes_r;

  logic [FW-1:0]   p_r;
  logic [FW-1:0]   q_r;
  logic [FW-1:0]   sq_r;
  logic [FW-1:0]   f_r;
  logic [2*MW-1:0] prod_r;
  logic            end_r;
  logic            done_r;
  logic            zero_r;

  logic            out_valid_r;
  logic [17:0]     x_r;
  logic [17:0]     y_r;
  logic            pass_end_r;
  logic            done_res_r;

  logic [DW-1:0]   d_len;
  logic [PW-1:0]   start_pos;
  logic [PW-1:0]   cross_pos;
  logic            neg;
  logic            horiz;

  logic            in_acc;
  logic [7:0]      pl;
  logic [17:0]     fi;
  logic            is_done;
  logic            end_now;
  logic [DW-1:0]   t_clamp;
  logic            div_start;
  logic [FW-1:0]   div_quot;
  logic            div_done;

  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] prod;
  logic [FW-1:0]   cu;
  logic [VW-1:0]   blend;
  logic [FW-1:0]   f_fin;

  logic [2*MW:0]   rnd;
  logic [DW-1:0]   off;
  logic [PW-1:0]   scroll;
  logic [PW-1:0]   x_pos;
  logic [PW-1:0]   y_pos;
  logic            out_load;

  // Run geometry and cross-axis placement from the configuration.
  always_comb begin
    case (dir_r)
      DIR_LEFT: begin
        d_len     = DW'(ww_r) + DW'(cw_r);
        start_pos = PW'(ww_r);
        neg       = 1'b1;
        horiz     = 1'b1;
      end
      DIR_RIGHT: begin
        d_len     = DW'(ww_r) + DW'(cw_r);
        start_pos = PW'(0) - PW'(cw_r);
        neg       = 1'b0;
        horiz     = 1'b1;
      end
      DIR_UP: begin
        d_len     = DW'(wh_r) + DW'({ch_r, 1'b0});
        start_pos = PW'(wh_r);
        neg       = 1'b1;
        horiz     = 1'b0;
      end
      default: begin
        d_len     = DW'(wh_r) + DW'(ch_r);
        start_pos = PW'(0) - PW'(ch_r);
        neg       = 1'b0;
        horiz     = 1'b0;
      end
    endcase

    case (align_r)
      ALIGN_FAR: begin
        cross_pos = horiz ? (PW'(wh_r) - PW'(ch_r)) : (PW'(ww_r) - PW'(cw_r));
      end
      ALIGN_CENTER: begin
        cross_pos = horiz ? (PW'(wh_r >> 1) - PW'(CENTER_OFFSET))
                          : (PW'(ww_r >> 1) - PW'(cw_r >> 1));
      end
      default: begin
        cross_pos = '0;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pl        = in_restart ? pcnt_r : passes_r;
  assign fi        = in_restart ? '0 : frame_r;
  assign is_done   = (pl == '0);
  assign end_now   = (fi >= 18'(d_len));
  assign t_clamp   = end_now ? d_len : fi[DW-1:0];
  assign div_start = in_acc && !is_done && (d_len != '0);

  sepg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t_clamp),
    .divisor  (d_len),
    .quot     (div_quot),
    .done     (div_done)
  );

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = MW'(q_r);
        mul_b = MW'(q_r);
      end
      S_MUL2: begin
        mul_a = MW'(prod_r[FRACTION_BITS +: FW]);
        mul_b = MW'(q_r);
      end
      S_MUL3: begin
        mul_a = MW'(d_len);
        mul_b = MW'(f_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Ease fraction from the cube and square of the shaped progress.
  always_comb begin
    cu    = prod_r[FRACTION_BITS +: FW];
    blend = (VW'(cu) << 2) + VW'(p_r) + (VW'(p_r) << 1)
          - (VW'(sq_r) << 2) - (VW'(sq_r) << 1);
    case (kind_r)
      EASE_IN: begin
        f_fin = cu;
      end
      EASE_OUT: begin
        f_fin = FX_ONE - cu;
      end
      EASE_IN_OUT: begin
        f_fin = (p_r < FX_HALF) ? (cu >> 1) : (FX_ONE - (cu >> 1));
      end
      EASE_OUT_IN: begin
        if (blend[VW-1]) begin
          f_fin = '0;
        end else if (blend > VW'(FX_ONE)) begin
          f_fin = FX_ONE;
        end else begin
          f_fin = blend[FW-1:0];
        end
      end
      default: begin
        f_fin = p_r;
      end
    endcase
  end

  // Rounded offset and final positions.
  always_comb begin
    rnd    = (2*MW+1)'(prod_r) + (2*MW+1)'(FX_HALF);
    off    = rnd[FRACTION_BITS +: DW];
    if (zero_r) begin
      scroll = '0;
    end else if (neg) begin
      scroll = start_pos - PW'(off);
    end else begin
      scroll = start_pos + PW'(off);
    end
    x_pos = horiz ? scroll : cross_pos;
    y_pos = horiz ? cross_pos : scroll;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= '0;
      align_r     <= '0;
      kind_r      <= '0;
      ww_r        <= '0;
      wh_r        <= '0;
      cw_r        <= '0;
      ch_r        <= '0;
      pcnt_r      <= '0;
      frame_r     <= '0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DIRECTION:      dir_r   <= cfg_data[1:0];
          REG_ALIGNMENT:      align_r <= cfg_data[1:0];
          REG_EASE_KIND:      kind_r  <= cfg_data[2:0];
          REG_WINDOW_WIDTH:   ww_r    <= cfg_data[13:0];
          REG_WINDOW_HEIGHT:  wh_r    <= cfg_data[13:0];
          REG_CONTENT_WIDTH:  cw_r    <= cfg_data;
          REG_CONTENT_HEIGHT: ch_r    <= cfg_data[13:0];
          REG_PASS_COUNT:     pcnt_r  <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_done) begin
              passes_r <= pl;
              frame_r  <= fi;
              state_r  <= S_OUT;
            end else begin
              if (end_now) begin
                frame_r  <= '0;
                passes_r <= pl - 8'd1;
              end else begin
                frame_r  <= fi + 18'd1;
                passes_r <= pl;
              end
              state_r <= (d_len == '0) ? S_EASE : S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_EASE;
          end
        end
        S_EASE: begin
          case (kind_r)
            EASE_LINEAR:                               state_r <= S_MUL3;
            EASE_IN, EASE_OUT, EASE_IN_OUT, EASE_OUT_IN: state_r <= S_MUL1;
            default:                                   state_r <= S_OUT;
          endcase
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_FIN;
        S_FIN:  state_r <= S_MUL3;
        S_MUL3: state_r <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          done_r <= is_done;
          end_r  <= end_now;
          zero_r <= 1'b0;
          p_r    <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          p_r <= div_quot;
        end
      end
      S_EASE: begin
        case (kind_r)
          EASE_LINEAR: f_r <= p_r;
          EASE_IN:     q_r <= p_r;
          EASE_OUT:    q_r <= FX_ONE - p_r;
          EASE_IN_OUT: q_r <= (p_r < FX_HALF) ? (p_r << 1) : ((FX_ONE - p_r) << 1);
          EASE_OUT_IN: q_r <= p_r;
          default:     zero_r <= 1'b1;
        endcase
      end
      S_MUL1: begin
        prod_r <= prod;
      end
      S_MUL2: begin
        sq_r   <= prod_r[FRACTION_BITS +: FW];
        prod_r <= prod;
      end
      S_FIN: begin
        f_r <= f_fin;
      end
      S_MUL3: begin
        prod_r <= prod;
      end
      default: ;
    endcase

    if (out_load) begin
      x_r        <= done_r ? '0 : x_pos[17:0];
      y_r        <= done_r ? '0 : y_pos[17:0];
      pass_end_r <= !done_r && end_r;
      done_res_r <= done_r;
    end
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_x_position = $signed(x_r);
  assign out_y_position = $signed(y_r);
  assign out_pass_end   = pass_end_r;
  assign out_done_res   = done_res_r;

endmodule

FILE: rtl/core/sepg_div.sv
// Restoring divider that gives floor(t * ONE / d) for t no larger than d.
// One quotient bit per cycle.
// Depends on sepg_pkg.
module sepg_div
  import sepg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [FW-1:0] quot,
  output logic          done
);

  localparam int CNTW = $clog2(FW + 1);

  logic [DW:0]     rem_r;
  logic [DW:0]     rem_nxt;
  logic [DW-1:0]   div_r;
  logic [FW-1:0]   quot_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            ge;
  logic [DW:0]     diff;

  always_comb begin
    ge      = rem_r >= {1'b0, div_r};
    diff    = ge ? (rem_r - {1'b0, div_r}) : rem_r;
    rem_nxt = {diff[DW-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(FW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[FW-2:0], ge};
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule
